// ===== design/etot_pkg.sv =====
// Package with the shared constants, types and helper functions of the totient block.
`default_nettype none
package etot_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int FIELD_WIDTH = 32;
    localparam int DIV_WIDTH   = VALUE_WIDTH / 2 + 1;
    localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH + 1);

    typedef logic [VALUE_WIDTH-1:0] t_value;
    typedef logic [DIV_WIDTH-1:0]   t_trial;
    typedef logic [FIELD_WIDTH-1:0] t_field;

    typedef struct packed {
        logic   start;
        t_value dividend;
        t_value divisor;
    } t_div_req;

    typedef struct packed {
        logic   done;
        t_value quotient;
        t_value remainder;
    } t_div_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK_GO,
        S_CHK_WAIT,
        S_ACC_GO,
        S_ACC_WAIT,
        S_FIN_GO,
        S_FIN_WAIT,
        S_DONE
    } t_state;

    function automatic t_value field_to_value(input t_field f);
        logic [127:0] wide;
        wide = 128'(f);
        return wide[VALUE_WIDTH-1:0];
    endfunction

    function automatic t_field value_to_field(input t_value v);
        logic [127:0] wide;
        wide = 128'(v);
        return wide[FIELD_WIDTH-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== design/etot_div.sv =====
// Shared restoring divider that produces one quotient bit per cycle.
`default_nettype none
module etot_div import etot_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_WIDTH-1:0] r_cnt;
    t_value               r_rem;
    t_value               r_quo;
    t_value               r_den;
    t_value               n_rem;
    t_value               n_quo;
    logic [VALUE_WIDTH:0] shifted;
    logic [VALUE_WIDTH:0] diff;

    always_comb begin
        shifted = {r_rem, r_quo[VALUE_WIDTH-1]};
        diff    = shifted - {1'b0, r_den};
        if (!diff[VALUE_WIDTH]) begin
            n_rem = diff[VALUE_WIDTH-1:0];
            n_quo = {r_quo[VALUE_WIDTH-2:0], 1'b1};
        end else begin
            n_rem = shifted[VALUE_WIDTH-1:0];
            n_quo = {r_quo[VALUE_WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_WIDTH'(VALUE_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_WIDTH'(1);
                if (r_cnt == CNT_WIDTH'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule
`default_nettype wire

// ===== design/etot_seq.sv =====
// Sequencer that runs trial division through the shared divider and holds the result.
`default_nettype none
module etot_seq import etot_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_field   i_in_data,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output t_field        o_out_data,
    input  wire logic     i_out_ready,
    output t_div_req      o_req,
    input  wire t_div_rsp i_rsp
);

    t_state r_state;
    t_state n_state;
    t_value r_rest;
    t_value n_rest;
    t_value r_acc;
    t_value n_acc;
    t_trial r_d;
    t_trial n_d;
    logic   r_found;
    logic   n_found;
    logic   r_out_valid;
    logic   n_out_valid;
    t_field r_out_data;
    t_field n_out_data;
    t_value d_ext;
    logic   rem_zero;

    assign d_ext    = VALUE_WIDTH'(r_d);
    assign rem_zero = (i_rsp.remainder == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rest     <= n_rest;
        r_acc      <= n_acc;
        r_d        <= n_d;
        r_out_data <= n_out_data;
    end

    always_comb begin
        n_state        = r_state;
        n_rest         = r_rest;
        n_acc          = r_acc;
        n_d            = r_d;
        n_found        = r_found;
        n_out_valid    = r_out_valid;
        n_out_data     = r_out_data;
        o_req.start    = 1'b0;
        o_req.dividend = r_rest;
        o_req.divisor  = d_ext;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_rest  = field_to_value(i_in_data);
                    n_acc   = field_to_value(i_in_data);
                    n_d     = DIV_WIDTH'(2);
                    n_found = 1'b0;
                    n_state = S_CHK_GO;
                end
            end
            S_CHK_GO: begin
                o_req.start = 1'b1;
                n_state     = S_CHK_WAIT;
            end
            S_CHK_WAIT: begin
                if (i_rsp.done) begin
                    if (r_found) begin
                        if (rem_zero) begin
                            n_rest  = i_rsp.quotient;
                            n_state = S_CHK_GO;
                        end else begin
                            n_state = S_ACC_GO;
                        end
                    end else if (d_ext > i_rsp.quotient) begin
                        n_state = (r_rest > VALUE_WIDTH'(1)) ? S_FIN_GO : S_DONE;
                    end else if (rem_zero) begin
                        n_rest  = i_rsp.quotient;
                        n_found = 1'b1;
                        n_state = S_CHK_GO;
                    end else begin
                        n_d     = r_d + DIV_WIDTH'(1);
                        n_state = S_CHK_GO;
                    end
                end
            end
            S_ACC_GO: begin
                o_req.start    = 1'b1;
                o_req.dividend = r_acc;
                n_state        = S_ACC_WAIT;
            end
            S_ACC_WAIT: begin
                if (i_rsp.done) begin
                    n_acc   = r_acc - i_rsp.quotient;
                    n_found = 1'b0;
                    n_d     = r_d + DIV_WIDTH'(1);
                    n_state = S_CHK_GO;
                end
            end
            S_FIN_GO: begin
                o_req.start    = 1'b1;
                o_req.dividend = r_acc;
                o_req.divisor  = r_rest;
                n_state        = S_FIN_WAIT;
            end
            S_FIN_WAIT: begin
                if (i_rsp.done) begin
                    n_acc   = r_acc - i_rsp.quotient;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = value_to_field(r_acc);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
`default_nettype wire

// ===== design/euler_totient.sv =====
// Top level of the Euler totient block.
// Usage: one unsigned integer n arrives per transfer on the slave stream
// (i_s_axis_tdata) and phi(n) leaves as one transfer on the master stream
// (o_m_axis_tdata). Every input transfer yields exactly one output transfer.
// The work runs by trial division through one shared restoring divider that
// yields one quotient bit per cycle. An item needs one division per trial
// divisor up to the square root of the shrinking remainder, one more per
// factor taken out and one per distinct prime. The sequencer holds one
// item at a time; o_s_axis_tready is high only while it is idle.
// The result sits in an output register; when the receiver stalls, the
// sequencer still accepts and computes the next item and waits only to load
// its result until that register is free.
// Reset (synchronous, active low) empties the output register and returns
// the sequencer to idle; no other state is kept between items.
`default_nettype none
module euler_totient import etot_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,  // [31:0] value_in
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata   // [31:0] totient
);

    t_div_req div_req;
    t_div_rsp div_rsp;

    etot_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_data   (i_s_axis_tdata),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata),
        .i_out_ready (i_m_axis_tready),
        .o_req       (div_req),
        .i_rsp       (div_rsp)
    );

    etot_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

endmodule
`default_nettype wire

// ===== design/etot_checker.sv =====
// Port-level checker for the totient block and its bind to the top level.
`default_nettype none
module etot_port_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic [31:0] i_s_axis_tdata,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [31:0] o_m_axis_tdata
);

    logic in_xfer;

    assign in_xfer = i_s_axis_tvalid && o_s_axis_tready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output transfer dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !o_s_axis_tready)
        else $error("input accepted again while an item is in progress");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !$rose(o_m_axis_tvalid))
        else $error("result appeared right after the input transfer");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("block not empty and idle after reset");

endmodule

bind euler_totient etot_port_checker u_etot_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
`default_nettype wire

// ===== tb/sv/etot_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts phi(n) for every input transfer and compares it with the output stream.
module etot_checker import etot_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_in_data,   // [31:0] value_in
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_data,  // [31:0] totient
    output int          o_fail_count,
    output int          o_pending
);

    t_field totient_q[$];

    function automatic t_field phi_of(input logic [31:0] word);
        logic [63:0] mask;
        logic [63:0] rest;
        logic [63:0] acc;
        logic [63:0] d;
        mask = (VALUE_WIDTH >= 64) ? '1 : (64'd1 << VALUE_WIDTH) - 64'd1;
        rest = 64'(word) & mask;
        acc  = rest;
        for (d = 2; d <= rest / d; d++) begin
            if (rest % d == 0) begin
                while (rest % d == 0) begin
                    rest = rest / d;
                end
                acc = acc - acc / d;
            end
        end
        if (rest > 1) begin
            acc = acc - acc / rest;
        end
        return t_field'(acc[FIELD_WIDTH-1:0]);
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_field want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (totient_q.size() == 0) begin
                    $error("totient: transfer with no value pending, actual %0d", i_out_data);
                    o_fail_count++;
                end else begin
                    want = totient_q.pop_front();
                    if (i_out_data !== want) begin
                        $error("totient: expected %0d, actual %0d", want, i_out_data);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                totient_q.push_back(phi_of(i_in_data));
            end
            o_pending = totient_q.size();
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top that drives directed and random integers into the totient block and reports the verdict.
module tb_top;
    import etot_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int TRIAL_BUDGET   = 512;
    localparam int RANDOM_ITEMS   = 90;

    logic        clk;
    logic        rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_data;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_data;
    int          fail_count;
    int          pending;
    int          quiet_cycles = 0;
    bit          tx_idle_en = 1'b0;
    bit          rx_idle_en = 1'b0;

    // Zero, one, small primes and powers, prime squares and wide values with only small
    // factors; wide primes are left out since they need the most trial divisions.
    logic [31:0] corner_values[$] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd8, 32'd9,
        32'd12, 32'd30, 32'd97, 32'd63001, 32'd65537, 32'd4293984256,
        32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_0000, 32'hAAAA_AAAA,
        32'h5555_5555, 32'hC000_0000, 32'd3486784401, 32'd223092870
    };

    euler_totient DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    etot_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (s_valid),
        .i_in_ready   (s_ready),
        .i_in_data    (s_data),
        .i_out_valid  (m_valid),
        .i_out_ready  (m_ready),
        .i_out_data   (m_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(12, 70);
    endfunction

    // True when the trial-division loop for n stays within the trial budget.
    function automatic bit is_quick(input logic [31:0] n);
        logic [63:0] rest;
        logic [63:0] d;
        int          trials;
        rest   = 64'(n);
        trials = 0;
        for (d = 2; d <= rest / d; d++) begin
            trials++;
            if (trials > TRIAL_BUDGET) return 1'b0;
            while (rest % d == 0) begin
                rest = rest / d;
            end
        end
        return 1'b1;
    endfunction

    function automatic logic [31:0] next_value();
        logic [63:0] v;
        int          m;
        int          kind;
        kind = $urandom_range(0, 9);
        if (kind < 3) return 32'($urandom_range(0, 65535));
        if (kind < 6) begin
            for (int t = 0; t < 300; t++) begin
                v = 64'($urandom()) >> $urandom_range(0, 12);
                if (is_quick(v[31:0])) return v[31:0];
            end
        end
        // A product of small random factors reaches the top bits and stays fast.
        v = 64'($urandom_range(1, 255));
        for (int k = 0; k < 40; k++) begin
            m = $urandom_range(2, 400);
            if (v * m > 64'hFFFF_FFFF) break;
            v = v * m;
        end
        return v[31:0];
    endfunction

    task automatic send_value(input logic [31:0] value);
        int gap;
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= value;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        @(negedge clk);
    endtask

    initial begin
        int stall_left;
        stall_left = 0;
        m_ready    = 1'b1;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
                stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                        : $urandom_range(15, 60);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        s_valid = 1'b0;
        s_data  = '0;
        rst_n   = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (corner_values[i]) begin
            send_value(corner_values[i]);
        end

        // Hold off the sender until the block has drained every pending transfer.
        s_valid <= 1'b0;
        while (pending != 0) @(negedge clk);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            tx_idle_en = ((i / 15) % 3) != 2;
            rx_idle_en = ((i / 15) % 4) != 3;
            send_value(next_value());
        end

        s_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/etot_pkg.sv
design/etot_div.sv
design/etot_seq.sv
design/euler_totient.sv
design/etot_checker.sv
tb/sv/etot_checker.sv
tb/sv/tb_top.sv
